### hw/rtl/hierarchical_round_robin_selector_unit_macros.svh
// Assertion macros for the round-robin selector checker.
// Used by the checker file only; needs i_clk and i_rst_n in scope.
`ifndef HIERARCHICAL_ROUND_ROBIN_SELECTOR_UNIT_MACROS_SVH
`define HIERARCHICAL_ROUND_ROBIN_SELECTOR_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define HRRS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("hrrs: same-cycle check failed");

// Next-cycle implication, disabled while reset is low
`define HRRS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("hrrs: next-cycle check failed");

`endif

### hw/rtl/hrrs_pkg.sv
// Shared types, dimensions and index helpers for the round-robin selector.
// No dependencies; imported by every module of the block.
package hrrs_pkg;

    // Grid dimensions and their usable part (index fields are two bits)
    localparam int GROUPS          = 4;
    localparam int HOSTS_PER_GROUP = 4;
    localparam int SLOTS_PER_HOST  = 4;

    localparam int EFF_G     = (GROUPS < 4) ? GROUPS : 4;
    localparam int EFF_H     = (HOSTS_PER_GROUP < 4) ? HOSTS_PER_GROUP : 4;
    localparam int EFF_S     = (SLOTS_PER_HOST < 4) ? SLOTS_PER_HOST : 4;
    localparam int NUM_HOSTS = EFF_G * EFF_H;

    localparam int IDX_W = 2;
    localparam int ROW_W = (NUM_HOSTS > 1) ? $clog2(NUM_HOSTS) : 1;
    localparam int GI_W  = (EFF_G > 1) ? $clog2(EFF_G) : 1;

    localparam logic [IDX_W-1:0] G_LAST = IDX_W'(EFF_G - 1);
    localparam logic [IDX_W-1:0] H_LAST = IDX_W'(EFF_H - 1);
    localparam logic [IDX_W-1:0] S_LAST = IDX_W'(EFF_S - 1);

    typedef enum logic [3:0] {
        OP_ADD        = 4'd0,
        OP_REMOVE     = 4'd1,
        OP_CONNECT    = 4'd2,
        OP_DISCONNECT = 4'd3,
        OP_PICK_ANY   = 4'd4,
        OP_PICK_GROUP = 4'd5,
        OP_BCAST_GRP  = 4'd6,
        OP_BCAST_HOST = 4'd7,
        OP_BCAST_ALL  = 4'd8
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PICK,
        ST_BGRP,
        ST_BHOST,
        ST_BALL,
        ST_FLUSH
    } t_state;

    // One host's slot bits
    typedef logic [EFF_S-1:0] t_row;

    // Finder result: first qualifying slot from the start position
    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] idx;
    } t_find;

    // Step an index by one, wrapping after the last position
    function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] x,
                                                  input logic [IDX_W-1:0] last_idx);
        wrap_inc = (x == last_idx) ? '0 : x + 1'b1;
    endfunction

    // Add an offset to a base index modulo a small count (both below the count)
    function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] base,
                                                  input logic [IDX_W-1:0] off,
                                                  input int               cnt);
        logic [IDX_W:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= (IDX_W+1)'(cnt)) begin
            sum = sum - (IDX_W+1)'(cnt);
        end
        wrap_add = sum[IDX_W-1:0];
    endfunction

    // Flat host row of a group and host
    function automatic logic [ROW_W-1:0] row_of(input logic [IDX_W-1:0] g,
                                                input logic [IDX_W-1:0] h);
        row_of = ROW_W'(int'(g) * EFF_H + int'(h));
    endfunction

    // One-hot mask of a slot within a row
    function automatic t_row slot_mask(input logic [IDX_W-1:0] s);
        t_row m;
        for (int i = 0; i < EFF_S; i++) begin
            m[i] = (s == IDX_W'(i));
        end
        slot_mask = m;
    endfunction

    // Mask of slots at or above a position
    function automatic t_row from_mask(input logic [IDX_W-1:0] s);
        t_row m;
        for (int i = 0; i < EFF_S; i++) begin
            m[i] = (IDX_W'(i) >= s);
        end
        from_mask = m;
    endfunction

endpackage

### hw/rtl/hrrs_finder.sv
// Rotating first-set search over one host row: the shared scan unit.
// Depends on hrrs_pkg.
module hrrs_finder
    import hrrs_pkg::*;
(
    input  t_row             i_row,
    input  logic [IDX_W-1:0] i_start,
    output t_find            o_find
);

    // Scan from the start position, wrapping; the nearest set bit wins
    always_comb begin
        logic [IDX_W-1:0] c;
        o_find = '0;
        for (int i = EFF_S - 1; i >= 0; i--) begin
            c = wrap_add(i_start, IDX_W'(i), EFF_S);
            if (|(i_row & slot_mask(c))) begin
                o_find.hit = 1'b1;
                o_find.idx = c;
            end
        end
    end

endmodule

### hw/rtl/hierarchical_round_robin_selector_unit.sv
// Top level of the hierarchical round-robin selector: sequencer, slot state, output register.
// Depends on hrrs_pkg and hrrs_finder.
//
//  channel | direction | handshake                | payload
//  in      | to block  | i_in_valid / o_in_stall  | i_op i_group i_host i_slot
//  out     | from block| o_out_valid / i_out_stall| o_found o_out_group o_out_host o_out_slot o_last
//
// Add, remove, connect, disconnect and unknown codes are done at accept and leave the block idle.
// Picks test one host row per cycle in the shared finder while the output is free.
// Broadcast per group stops in each group at its first hit; per host tests every host row in turn.
// Broadcast all steps from each present slot to the next within a host row, then moves to the next row.
// Every broadcast, and a pick group out of range, ends in the flush state that gives the final result.
// Reset clears every slot bit and pointer; a stalled output holds the scan.
module hierarchical_round_robin_selector_unit
    import hrrs_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic [3:0]       i_op,
    input  logic [IDX_W-1:0] i_group,
    input  logic [IDX_W-1:0] i_host,
    input  logic [IDX_W-1:0] i_slot,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic             o_found,
    output logic [IDX_W-1:0] o_out_group,
    output logic [IDX_W-1:0] o_out_host,
    output logic [IDX_W-1:0] o_out_slot,
    output logic             o_last
);

    // Slot state and round-robin pointers
    t_row             r_present [NUM_HOSTS];
    t_row             r_up      [NUM_HOSTS];
    logic [IDX_W-1:0] r_hptr    [NUM_HOSTS];
    logic [IDX_W-1:0] r_gptr    [EFF_G];
    logic [IDX_W-1:0] r_pool;

    // Sequencer
    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_g, n_g;
    logic [IDX_W-1:0] r_hcnt, n_hcnt;
    logic [IDX_W-1:0] r_gcnt, n_gcnt;
    logic [IDX_W-1:0] r_s, n_s;
    logic             r_any, n_any;

    // Held broadcast result, waiting to learn whether it is the final one
    logic             r_pend_valid, n_pend_valid;
    logic [IDX_W-1:0] r_pend_g, n_pend_g;
    logic [IDX_W-1:0] r_pend_h, n_pend_h;
    logic [IDX_W-1:0] r_pend_s, n_pend_s;

    // Output register
    logic             r_out_valid, n_out_valid;
    logic             r_out_found, n_out_found;
    logic [IDX_W-1:0] r_out_g, n_out_g;
    logic [IDX_W-1:0] r_out_h, n_out_h;
    logic [IDX_W-1:0] r_out_s, n_out_s;
    logic             r_out_last, n_out_last;

    // Datapath
    logic             accept, out_free, in_ok;
    logic [IDX_W-1:0] gptr_cur, cur_h, hptr_cur;
    logic [ROW_W-1:0] row_addr;
    t_row             row_pres, row_up, fnd_row, smask;
    logic [IDX_W-1:0] fnd_start;
    t_find            fnd;
    logic             h_last, g_last, gc_last;

    // Write strobes
    logic             pres_we, up_we, hp_we, gp_we, pool_we;
    t_row             pres_wd, up_wd;
    logic [IDX_W-1:0] hp_wd, gp_wd, pool_wd;

    // Result moves
    logic             rec;
    logic [IDX_W-1:0] rec_g, rec_h, rec_s;

    assign accept     = i_in_valid && (r_state == ST_IDLE);
    assign o_in_stall = (r_state != ST_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;

    assign in_ok = ({1'b0, i_group} < (IDX_W+1)'(EFF_G)) &&
                   ({1'b0, i_host}  < (IDX_W+1)'(EFF_H)) &&
                   ({1'b0, i_slot}  < (IDX_W+1)'(EFF_S));

    // Select the host row under test: input address when idle, scan position otherwise
    assign gptr_cur = r_gptr[r_g[GI_W-1:0]];
    assign cur_h    = (r_state == ST_PICK || r_state == ST_BGRP) ?
                      wrap_add(gptr_cur, r_hcnt, EFF_H) : r_hcnt;
    assign row_addr = (r_state == ST_IDLE) ? row_of(i_group, i_host) : row_of(r_g, cur_h);
    assign row_pres = r_present[row_addr];
    assign row_up   = r_up[row_addr];
    assign hptr_cur = r_hptr[row_addr];
    assign smask    = slot_mask(i_slot);

    assign fnd_row   = (r_state == ST_BALL) ? (row_pres & from_mask(r_s)) : (row_pres & row_up);
    assign fnd_start = (r_state == ST_BALL) ? r_s : hptr_cur;

    hrrs_finder u_finder (
        .i_row   (fnd_row),
        .i_start (fnd_start),
        .o_find  (fnd)
    );

    assign h_last  = (r_hcnt == H_LAST);
    assign g_last  = (r_g == G_LAST);
    assign gc_last = (r_gcnt == G_LAST);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    unique case (t_op'(i_op))
                        OP_PICK_ANY:   n_state = ST_PICK;
                        OP_PICK_GROUP: n_state = ({1'b0, i_group} < (IDX_W+1)'(EFF_G)) ?
                                                 ST_PICK : ST_FLUSH;
                        OP_BCAST_GRP:  n_state = ST_BGRP;
                        OP_BCAST_HOST: n_state = ST_BHOST;
                        OP_BCAST_ALL:  n_state = ST_BALL;
                        default:       n_state = ST_IDLE;
                    endcase
                end
            end
            ST_PICK: begin
                if (out_free && (fnd.hit || (h_last && (!r_any || gc_last)))) begin
                    n_state = ST_IDLE;
                end
            end
            ST_BGRP: begin
                if (out_free && (fnd.hit || h_last) && g_last) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_BHOST: begin
                if (out_free && h_last && g_last) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_BALL: begin
                if (out_free && (!fnd.hit || fnd.idx == S_LAST) && h_last && g_last) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs: state writes, scan position, results
    always_comb begin
        n_g          = r_g;
        n_hcnt       = r_hcnt;
        n_gcnt       = r_gcnt;
        n_s          = r_s;
        n_any        = r_any;
        n_pend_valid = r_pend_valid;
        n_pend_g     = r_pend_g;
        n_pend_h     = r_pend_h;
        n_pend_s     = r_pend_s;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_found  = r_out_found;
        n_out_g      = r_out_g;
        n_out_h      = r_out_h;
        n_out_s      = r_out_s;
        n_out_last   = r_out_last;
        pres_we      = 1'b0;
        up_we        = 1'b0;
        hp_we        = 1'b0;
        gp_we        = 1'b0;
        pool_we      = 1'b0;
        pres_wd      = row_pres;
        up_wd        = row_up;
        hp_wd        = wrap_inc(fnd.idx, S_LAST);
        gp_wd        = wrap_inc(cur_h, H_LAST);
        pool_wd      = wrap_inc(r_g, G_LAST);
        rec          = 1'b0;
        rec_g        = r_g;
        rec_h        = cur_h;
        rec_s        = fnd.idx;

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_hcnt       = '0;
                    n_gcnt       = '0;
                    n_s          = '0;
                    n_g          = '0;
                    n_pend_valid = 1'b0;
                    unique case (t_op'(i_op))
                        OP_ADD: begin
                            pres_we = in_ok;
                            pres_wd = row_pres | smask;
                        end
                        OP_REMOVE: begin
                            pres_we = in_ok;
                            up_we   = in_ok;
                            pres_wd = row_pres & ~smask;
                            up_wd   = row_up & ~smask;
                            // Move the host pointer off a removed slot
                            hp_we   = in_ok && (|(row_pres & smask)) && (hptr_cur == i_slot);
                            hp_wd   = wrap_inc(i_slot, S_LAST);
                        end
                        OP_CONNECT: begin
                            up_we = in_ok;
                            up_wd = row_up | smask;
                        end
                        OP_DISCONNECT: begin
                            up_we = in_ok;
                            up_wd = row_up & ~smask;
                        end
                        OP_PICK_ANY: begin
                            n_g   = r_pool;
                            n_any = 1'b1;
                        end
                        OP_PICK_GROUP: begin
                            n_g   = i_group;
                            n_any = 1'b0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_PICK: begin
                if (out_free) begin
                    if (fnd.hit) begin
                        hp_we       = 1'b1;
                        gp_we       = 1'b1;
                        pool_we     = r_any;
                        n_out_valid = 1'b1;
                        n_out_found = 1'b1;
                        n_out_g     = r_g;
                        n_out_h     = cur_h;
                        n_out_s     = fnd.idx;
                        n_out_last  = 1'b1;
                    end else if (h_last) begin
                        if (r_any && !gc_last) begin
                            // Advance to the next group of the pool
                            n_g    = wrap_inc(r_g, G_LAST);
                            n_gcnt = r_gcnt + 1'b1;
                            n_hcnt = '0;
                        end else begin
                            n_out_valid = 1'b1;
                            n_out_found = 1'b0;
                            n_out_g     = '0;
                            n_out_h     = '0;
                            n_out_s     = '0;
                            n_out_last  = 1'b1;
                        end
                    end else begin
                        n_hcnt = r_hcnt + 1'b1;
                    end
                end
            end
            ST_BGRP: begin
                if (out_free) begin
                    if (fnd.hit) begin
                        hp_we = 1'b1;
                        gp_we = 1'b1;
                        rec   = 1'b1;
                    end
                    if (fnd.hit || h_last) begin
                        n_hcnt = '0;
                        n_g    = wrap_inc(r_g, G_LAST);
                    end else begin
                        n_hcnt = r_hcnt + 1'b1;
                    end
                end
            end
            ST_BHOST: begin
                if (out_free) begin
                    if (fnd.hit) begin
                        hp_we = 1'b1;
                        rec   = 1'b1;
                    end
                    if (h_last) begin
                        n_hcnt = '0;
                        n_g    = wrap_inc(r_g, G_LAST);
                    end else begin
                        n_hcnt = r_hcnt + 1'b1;
                    end
                end
            end
            ST_BALL: begin
                if (out_free) begin
                    rec = fnd.hit;
                    if (fnd.hit && fnd.idx != S_LAST) begin
                        // More slots may follow in this row
                        n_s = fnd.idx + 1'b1;
                    end else begin
                        n_s = '0;
                        if (h_last) begin
                            n_hcnt = '0;
                            n_g    = wrap_inc(r_g, G_LAST);
                        end else begin
                            n_hcnt = r_hcnt + 1'b1;
                        end
                    end
                end
            end
            ST_FLUSH: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_found  = r_pend_valid;
                    n_out_g      = r_pend_valid ? r_pend_g : '0;
                    n_out_h      = r_pend_valid ? r_pend_h : '0;
                    n_out_s      = r_pend_valid ? r_pend_s : '0;
                    n_out_last   = 1'b1;
                    n_pend_valid = 1'b0;
                end
            end
            default: ;
        endcase

        // Release the held result and hold the new one
        if (rec) begin
            if (r_pend_valid) begin
                n_out_valid = 1'b1;
                n_out_found = 1'b1;
                n_out_g     = r_pend_g;
                n_out_h     = r_pend_h;
                n_out_s     = r_pend_s;
                n_out_last  = 1'b0;
            end
            n_pend_valid = 1'b1;
            n_pend_g     = rec_g;
            n_pend_h     = rec_h;
            n_pend_s     = rec_s;
        end
    end

    // Control state and slot state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_out_valid  <= 1'b0;
            r_pend_valid <= 1'b0;
            r_pool       <= '0;
            for (int i = 0; i < NUM_HOSTS; i++) begin
                r_present[i] <= '0;
                r_up[i]      <= '0;
                r_hptr[i]    <= '0;
            end
            for (int i = 0; i < EFF_G; i++) begin
                r_gptr[i] <= '0;
            end
        end else begin
            r_state      <= n_state;
            r_out_valid  <= n_out_valid;
            r_pend_valid <= n_pend_valid;
            if (pres_we) begin
                r_present[row_addr] <= pres_wd;
            end
            if (up_we) begin
                r_up[row_addr] <= up_wd;
            end
            if (hp_we) begin
                r_hptr[row_addr] <= hp_wd;
            end
            if (gp_we) begin
                r_gptr[r_g[GI_W-1:0]] <= gp_wd;
            end
            if (pool_we) begin
                r_pool <= pool_wd;
            end
        end
    end

    // Scan position and payload
    always_ff @(posedge i_clk) begin
        r_g         <= n_g;
        r_hcnt      <= n_hcnt;
        r_gcnt      <= n_gcnt;
        r_s         <= n_s;
        r_any       <= n_any;
        r_pend_g    <= n_pend_g;
        r_pend_h    <= n_pend_h;
        r_pend_s    <= n_pend_s;
        r_out_found <= n_out_found;
        r_out_g     <= n_out_g;
        r_out_h     <= n_out_h;
        r_out_s     <= n_out_s;
        r_out_last  <= n_out_last;
    end

    assign o_out_valid = r_out_valid;
    assign o_found     = r_out_found;
    assign o_out_group = r_out_g;
    assign o_out_host  = r_out_h;
    assign o_out_slot  = r_out_s;
    assign o_last      = r_out_last;

endmodule

### hw/rtl/hrrs_checker.sv
// Port-level checks for the round-robin selector, bound to the top level.
// Depends on hrrs_pkg and the assertion macro header.
`include "hierarchical_round_robin_selector_unit_macros.svh"

module hrrs_checker
    import hrrs_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             o_in_stall,
    input logic [3:0]       i_op,
    input logic             o_out_valid,
    input logic             i_out_stall,
    input logic             o_found,
    input logic [IDX_W-1:0] o_out_group,
    input logic [IDX_W-1:0] o_out_host,
    input logic [IDX_W-1:0] o_out_slot,
    input logic             o_last
);

    logic in_xfer;
    logic upd_op;
    logic idx_zero;

    assign in_xfer  = i_in_valid && !o_in_stall;
    assign upd_op   = (i_op == OP_ADD) || (i_op == OP_REMOVE) ||
                      (i_op == OP_CONNECT) || (i_op == OP_DISCONNECT);
    assign idx_zero = (o_out_group == '0) && (o_out_host == '0) && (o_out_slot == '0);

    // A stalled result stays offered
    `HRRS_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid)
    // An empty result carries zero indices and closes its item
    `HRRS_ASSERT_NOW(a_empty_zero, o_out_valid && !o_found, idx_zero)
    `HRRS_ASSERT_NOW(a_empty_last, o_out_valid && !o_found, o_last)
    // Slot updates leave the block idle; picks keep the block busy
    `HRRS_ASSERT_NEXT(a_update_free, in_xfer && upd_op, !o_in_stall)
    `HRRS_ASSERT_NEXT(a_pick_busy, in_xfer && i_op == OP_PICK_ANY, o_in_stall)

endmodule

bind hierarchical_round_robin_selector_unit hrrs_checker u_hrrs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_op        (i_op),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_found     (o_found),
    .o_out_group (o_out_group),
    .o_out_host  (o_out_host),
    .o_out_slot  (o_out_slot),
    .o_last      (o_last)
);

### tb/hrrs_tb_pkg.sv
// Expected-pick tracker for the round-robin selector testbench.
// Depends on hrrs_pkg for the grid dimensions and operation codes.
package hrrs_tb_pkg;
    import hrrs_pkg::*;

    localparam int NUM_SLOTS = NUM_HOSTS * EFF_S;

    // One result transfer as seen on the output channel
    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] grp;
        logic [IDX_W-1:0] hst;
        logic [IDX_W-1:0] slt;
        logic             is_last;
    } t_pick;

    class rr_pick_tracker;
        bit               present   [NUM_SLOTS];
        bit               up        [NUM_SLOTS];
        bit [IDX_W-1:0]   host_ptr  [NUM_HOSTS];
        bit [IDX_W-1:0]   group_ptr [EFF_G];
        bit [IDX_W-1:0]   pool_ptr;
        t_pick            pending_picks [$];
        int unsigned      errors;

        function int flat(int g, int h, int s);
            return (g * EFF_H + h) * EFF_S + s;
        endfunction

        // Scan one host from its pointer; advance the pointer past the hit
        function bit pick_in_host(int g, int h, output int s);
            int row;
            int start;
            int c;
            int i;
            s = 0;
            row = g * EFF_H + h;
            start = host_ptr[row] % EFF_S;
            for (i = 0; i < EFF_S; i++) begin
                c = (start + i) % EFF_S;
                if (present[flat(g, h, c)] && up[flat(g, h, c)]) begin
                    host_ptr[row] = IDX_W'((c + 1) % EFF_S);
                    s = c;
                    return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        function bit pick_in_group(int g, output int h, output int s);
            int start;
            int c;
            int i;
            h = 0;
            s = 0;
            start = group_ptr[g] % EFF_H;
            for (i = 0; i < EFF_H; i++) begin
                c = (start + i) % EFF_H;
                if (pick_in_host(g, c, s)) begin
                    group_ptr[g] = IDX_W'((c + 1) % EFF_H);
                    h = c;
                    return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        function bit pick_in_pool(output int g, output int h, output int s);
            int start;
            int c;
            int i;
            g = 0;
            h = 0;
            s = 0;
            start = pool_ptr % EFF_G;
            for (i = 0; i < EFF_G; i++) begin
                c = (start + i) % EFF_G;
                if (pick_in_group(c, h, s)) begin
                    pool_ptr = IDX_W'((c + 1) % EFF_G);
                    g = c;
                    return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        function void push_pick(bit found, int g, int h, int s);
            t_pick p;
            p.found   = found;
            p.grp     = found ? IDX_W'(g) : '0;
            p.hst     = found ? IDX_W'(h) : '0;
            p.slt     = found ? IDX_W'(s) : '0;
            p.is_last = 1'b0;
            pending_picks.insert(pending_picks.size(), p);
        endfunction

        // Update the slot grid and queue the picks caused by one input transfer
        function void take_request(logic [3:0] op, logic [IDX_W-1:0] g_in,
                                   logic [IDX_W-1:0] h_in, logic [IDX_W-1:0] s_in);
            int  g;
            int  h;
            int  s;
            int  a;
            int  b;
            int  c;
            int  k;
            int  row;
            int  before_cnt;
            bit  in_range;
            bit  gives_result;
            g = g_in;
            h = h_in;
            s = s_in;
            in_range = (g < EFF_G) && (h < EFF_H) && (s < EFF_S);
            k = flat(g, h, s);
            row = g * EFF_H + h;
            before_cnt = pending_picks.size();
            gives_result = 1'b1;
            case (op)
                OP_ADD: begin
                    gives_result = 1'b0;
                    if (in_range) present[k] = 1'b1;
                end
                OP_REMOVE: begin
                    gives_result = 1'b0;
                    if (in_range) begin
                        // Step the host pointer off a slot that goes away
                        if (present[k] && (host_ptr[row] % EFF_S) == s) begin
                            host_ptr[row] = IDX_W'((s + 1) % EFF_S);
                        end
                        present[k] = 1'b0;
                        up[k] = 1'b0;
                    end
                end
                OP_CONNECT: begin
                    gives_result = 1'b0;
                    if (in_range) up[k] = 1'b1;
                end
                OP_DISCONNECT: begin
                    gives_result = 1'b0;
                    if (in_range) up[k] = 1'b0;
                end
                OP_PICK_ANY: begin
                    if (pick_in_pool(a, b, c)) push_pick(1'b1, a, b, c);
                end
                OP_PICK_GROUP: begin
                    if (g < EFF_G) begin
                        if (pick_in_group(g, b, c)) push_pick(1'b1, g, b, c);
                    end
                end
                OP_BCAST_GRP: begin
                    for (a = 0; a < EFF_G; a++) begin
                        if (pick_in_group(a, b, c)) push_pick(1'b1, a, b, c);
                    end
                end
                OP_BCAST_HOST: begin
                    for (a = 0; a < EFF_G; a++) begin
                        for (b = 0; b < EFF_H; b++) begin
                            if (pick_in_host(a, b, c)) push_pick(1'b1, a, b, c);
                        end
                    end
                end
                OP_BCAST_ALL: begin
                    for (a = 0; a < EFF_G; a++) begin
                        for (b = 0; b < EFF_H; b++) begin
                            for (c = 0; c < EFF_S; c++) begin
                                if (present[flat(a, b, c)]) push_pick(1'b1, a, b, c);
                            end
                        end
                    end
                end
                default: begin
                    gives_result = 1'b0;
                end
            endcase
            if (gives_result) begin
                // An empty scan still reports once, with found low
                if (pending_picks.size() == before_cnt) push_pick(1'b0, 0, 0, 0);
                pending_picks[pending_picks.size() - 1].is_last = 1'b1;
            end
        endfunction

        function void compare_field(string name, int want, int got);
            if (want != got) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        // Match one output transfer against the oldest expected pick
        function void check_pick(logic found, logic [IDX_W-1:0] grp, logic [IDX_W-1:0] hst,
                                 logic [IDX_W-1:0] slt, logic is_last);
            t_pick want;
            if (pending_picks.size() == 0) begin
                $display("%0t: unexpected result, expected none, %s %0d %0d/%0d/%0d last=%0d",
                         $time, "actual found=", found, grp, hst, slt, is_last);
                errors++;
                return;
            end
            want = pending_picks.pop_front();
            compare_field("found", want.found, found);
            compare_field("group", want.grp, grp);
            compare_field("host", want.hst, hst);
            compare_field("slot", want.slt, slt);
            compare_field("last", want.is_last, is_last);
        endfunction
    endclass

endpackage

### tb/tb_top.sv
// Top of the round-robin selector testbench: clock, reset, drivers and monitors.
// Depends on hrrs_pkg, hrrs_tb_pkg and the selector RTL.
module tb_top;
    import hrrs_pkg::*;
    import hrrs_tb_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int HOLD_CYCLES = 300;

    // Lowest and highest operation codes that the block ignores
    localparam logic [3:0] OP_BAD_FIRST = 4'd9;
    localparam logic [3:0] OP_BAD_LAST  = 4'd15;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_in_valid = 1'b0;
    logic             o_in_stall;
    logic [3:0]       i_op = '0;
    logic [IDX_W-1:0] i_group = '0;
    logic [IDX_W-1:0] i_host = '0;
    logic [IDX_W-1:0] i_slot = '0;
    logic             o_out_valid;
    logic             i_out_stall = 1'b0;
    logic             o_found;
    logic [IDX_W-1:0] o_out_group;
    logic [IDX_W-1:0] o_out_host;
    logic [IDX_W-1:0] o_out_slot;
    logic             o_last;

    rr_pick_tracker   picks;
    int unsigned      cycle_count = 0;
    bit               hold_go = 1'b0;
    int               hold_count = 0;
    int               stall_mode = 0;
    int               mode_left = 0;

    hierarchical_round_robin_selector_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_op        (i_op),
        .i_group     (i_group),
        .i_host      (i_host),
        .i_slot      (i_slot),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_found     (o_found),
        .o_out_group (o_out_group),
        .o_out_host  (o_out_host),
        .o_out_slot  (o_out_slot),
        .o_last      (o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Check output transfers first, then record the input transfer of the same edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                picks.check_pick(o_found, o_out_group, o_out_host, o_out_slot, o_last);
            end
            if (i_in_valid && !o_in_stall) begin
                picks.take_request(i_op, i_group, i_host, i_slot);
            end
        end
    end

    // Receiver: one long hold-off when asked, otherwise a changing stall pattern
    always @(posedge i_clk) begin
        if (hold_go && hold_count < HOLD_CYCLES) begin
            hold_count <= hold_count + 1;
            i_out_stall <= 1'b1;
        end else begin
            if (mode_left == 0) begin
                stall_mode <= $urandom_range(0, 3);
                mode_left <= $urandom_range(5, 60);
            end else begin
                mode_left <= mode_left - 1;
            end
            case (stall_mode)
                0: i_out_stall <= 1'b0;
                1: i_out_stall <= ($urandom_range(0, 99) < 30);
                2: i_out_stall <= ($urandom_range(0, 99) < 70);
                default: i_out_stall <= ~i_out_stall;
            endcase
        end
    end

    // Present one item and hold it until the transfer happens
    task automatic offer(input logic [3:0] op, input logic [IDX_W-1:0] g,
                         input logic [IDX_W-1:0] h, input logic [IDX_W-1:0] s);
        i_in_valid <= 1'b1;
        i_op <= op;
        i_group <= g;
        i_host <= h;
        i_slot <= s;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic pause_sender(input int cycles);
        if (cycles > 0) begin
            i_in_valid <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    // Let the monitor record the last transfer, then wait for every expected result
    task automatic wait_drained();
        @(posedge i_clk);
        while (picks.pending_picks.size() != 0) @(posedge i_clk);
    endtask

    // Mostly slot edits and picks, with a few unknown codes
    task automatic offer_random();
        int r;
        logic [3:0] op;
        r = $urandom_range(0, 99);
        if (r < 22)      op = OP_ADD;
        else if (r < 42) op = OP_CONNECT;
        else if (r < 50) op = OP_REMOVE;
        else if (r < 56) op = OP_DISCONNECT;
        else if (r < 66) op = OP_PICK_ANY;
        else if (r < 76) op = OP_PICK_GROUP;
        else if (r < 83) op = OP_BCAST_GRP;
        else if (r < 90) op = OP_BCAST_HOST;
        else if (r < 95) op = OP_BCAST_ALL;
        else             op = 4'($urandom_range(OP_BAD_FIRST, OP_BAD_LAST));
        offer(op, IDX_W'($urandom_range(0, 3)), IDX_W'($urandom_range(0, 3)),
              IDX_W'($urandom_range(0, 3)));
    endtask

    task automatic run_bursts(input int items);
        int left;
        int burst;
        left = items;
        while (left > 0) begin
            burst = $urandom_range(1, 12);
            if (burst > left) burst = left;
            repeat (burst) offer_random();
            left -= burst;
            if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 8));
        end
    endtask

    initial begin
        picks = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty grid: every pick and broadcast reports nothing found
        offer(OP_PICK_ANY, 0, 0, 0);
        offer(OP_PICK_GROUP, 3, 0, 0);
        offer(OP_BCAST_GRP, 0, 0, 0);
        offer(OP_BCAST_HOST, 0, 0, 0);
        offer(OP_BCAST_ALL, 0, 0, 0);
        // Corner slots; broadcast all lists present slots even when down
        offer(OP_ADD, 0, 0, 0);
        offer(OP_ADD, 3, 3, 3);
        offer(OP_CONNECT, 3, 3, 3);
        offer(OP_CONNECT, 1, 2, 1);
        offer(OP_BCAST_ALL, 0, 0, 0);
        offer(OP_PICK_ANY, 0, 0, 0);
        offer(OP_PICK_GROUP, 3, 0, 0);
        // Remove the slot a host pointer rests on
        offer(OP_REMOVE, 0, 0, 0);
        // Connect ahead of add, then add makes it eligible
        offer(OP_ADD, 1, 2, 1);
        offer(OP_ADD, 0, 0, 1);
        offer(OP_CONNECT, 0, 0, 1);
        offer(OP_BCAST_HOST, 0, 0, 0);
        offer(OP_BCAST_GRP, 0, 0, 0);
        offer(OP_DISCONNECT, 1, 2, 1);
        offer(OP_PICK_ANY, 0, 0, 0);
        offer(OP_REMOVE, 2, 1, 2);
        offer(OP_BAD_FIRST, 1, 1, 1);
        offer(OP_BAD_LAST, 3, 3, 3);
        offer(OP_PICK_GROUP, 2, 0, 0);

        // Let every expected pick come out before the random phase
        i_in_valid <= 1'b0;
        wait_drained();
        @(posedge i_clk);

        // Receiver holds off while the sender keeps the input busy
        hold_go <= 1'b1;
        repeat (20) offer_random();
        run_bursts(136);

        i_in_valid <= 1'b0;
        wait_drained();
        repeat (150) @(posedge i_clk);
        if (picks.errors == 0 && picks.pending_picks.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
